### design/ssm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssm_pkg
// Shared constants and types for the shear sort matrix block.
// ----------------------------------------------------------------------------
package ssm_pkg;

   localparam int SIDE_DEF = 8;
   localparam int VALUE_W  = 32;
   localparam int IDX_W    = 3;

   typedef enum logic [2:0] {
      ST_LOAD = 3'b001,
      ST_SORT = 3'b010,
      ST_EMIT = 3'b100
   } ssm_state_type;

   typedef struct packed {
      logic shift_in;
      logic shift_out;
      logic cx_en;
      logic cx_col;
      logic cx_odd;
   } ssm_cmd_type;

endpackage

### design/shear_sort_matrix_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shear_sort_matrix_top
// Shear sort of a SIDE x SIDE matrix of signed 32-bit values into snake order.
// ----------------------------------------------------------------------------
// One matrix takes SIDE*SIDE load transactions (one per cycle at most), then
// ceil(log2(SIDE*SIDE)) sort rounds of SIDE row passes and SIDE column passes
// each, then SIDE*SIDE result transactions (one per cycle at most).
// The sort time is set by the compare-exchange mesh, which does one odd or
// even transposition pass over all rows or all columns per cycle. The
// input is not ready while a matrix is sorted or emitted; results come out in
// row-major order with row, column and a last flag on the final element.
// ----------------------------------------------------------------------------
module shear_sort_matrix_top import ssm_pkg::*; #(
   parameter int SIDE = SIDE_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [VALUE_W-1:0] rsp_sorted_value,
   output logic [IDX_W-1:0]          rsp_row_index,
   output logic [IDX_W-1:0]          rsp_col_index,
   output logic                      rsp_last
);

   ssm_cmd_type cmd;

   ssm_ctrl #(.SIDE(SIDE)) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_row_index (rsp_row_index),
      .rsp_col_index (rsp_col_index),
      .rsp_last      (rsp_last),
      .cmd           (cmd)
   );

   ssm_datapath #(.SIDE(SIDE)) u_datapath (
      .clock            (clock),
      .cmd              (cmd),
      .req_value        (req_value),
      .rsp_sorted_value (rsp_sorted_value)
   );

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("load and emit active together");

   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |->
         (rsp_row_index == IDX_W'(SIDE - 1)) && (rsp_col_index == IDX_W'(SIDE - 1)))
      else $error("last flag away from final position");

   a_back_to_load: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last) |=> req_ready)
      else $error("no return to load after final transaction");

   a_emit_start: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> (rsp_row_index == '0) && (rsp_col_index == '0))
      else $error("emit does not start at origin");

endmodule

### design/ssm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssm_ctrl
// Sequencer: counts loads, sort passes and rounds, and emitted elements.
// ----------------------------------------------------------------------------
module ssm_ctrl import ssm_pkg::*; #(
   parameter int SIDE = SIDE_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [IDX_W-1:0]   rsp_row_index,
   output logic [IDX_W-1:0]   rsp_col_index,
   output logic               rsp_last,
   output ssm_cmd_type        cmd
);

   localparam int CELLS   = SIDE * SIDE;
   localparam int CNT_W   = $clog2(CELLS);
   localparam int PASS_W  = $clog2(SIDE);
   localparam int ROUNDS  = $clog2(CELLS);
   localparam int ROUND_W = $clog2(ROUNDS);

   ssm_state_type      state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [PASS_W-1:0]  pass_ff, pass_in;
   logic               colmode_ff, colmode_in;
   logic [ROUND_W-1:0] round_ff, round_in;
   logic [IDX_W-1:0]   row_ff, row_in;
   logic [IDX_W-1:0]   col_ff, col_in;
   logic               cnt_last;

   assign req_ready     = (state_ff == ST_LOAD);
   assign rsp_valid     = (state_ff == ST_EMIT);
   assign cnt_last      = (cnt_ff == CNT_W'(CELLS - 1));
   assign rsp_last      = cnt_last;
   assign rsp_row_index = row_ff;
   assign rsp_col_index = col_ff;

   assign cmd.shift_in  = req_valid && req_ready;
   assign cmd.shift_out = rsp_valid && rsp_ready;
   assign cmd.cx_en     = (state_ff == ST_SORT);
   assign cmd.cx_col    = colmode_ff;
   assign cmd.cx_odd    = pass_ff[0];

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      pass_in    = pass_ff;
      colmode_in = colmode_ff;
      round_in   = round_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               if (cnt_last) begin
                  cnt_in   = '0;
                  state_in = ST_SORT;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         ST_SORT: begin
            if (pass_ff == PASS_W'(SIDE - 1)) begin
               pass_in = '0;
               if (colmode_ff) begin
                  colmode_in = 1'b0;
                  if (round_ff == ROUND_W'(ROUNDS - 1)) begin
                     round_in = '0;
                     state_in = ST_EMIT;
                  end else begin
                     round_in = round_ff + 1'b1;
                  end
               end else begin
                  colmode_in = 1'b1;
               end
            end else begin
               pass_in = pass_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (rsp_ready) begin
               if (col_ff == IDX_W'(SIDE - 1)) begin
                  col_in = '0;
                  row_in = row_ff + 1'b1;
               end else begin
                  col_in = col_ff + 1'b1;
               end
               if (cnt_last) begin
                  cnt_in   = '0;
                  row_in   = '0;
                  col_in   = '0;
                  state_in = ST_LOAD;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         cnt_ff     <= '0;
         pass_ff    <= '0;
         colmode_ff <= 1'b0;
         round_ff   <= '0;
         row_ff     <= '0;
         col_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         pass_ff    <= pass_in;
         colmode_ff <= colmode_in;
         round_ff   <= round_in;
         row_ff     <= row_in;
         col_ff     <= col_in;
      end
   end

endmodule

### design/ssm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssm_datapath
// Register mesh holding the matrix: shift chain for load and emit, and one
// layer of parallel compare-exchange cells along rows or columns per cycle.
// ----------------------------------------------------------------------------
module ssm_datapath import ssm_pkg::*; #(
   parameter int SIDE = SIDE_DEF
) (
   input  logic                      clock,
   input  ssm_cmd_type               cmd,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic signed [VALUE_W-1:0] rsp_sorted_value
);

   localparam int CELLS = SIDE * SIDE;

   logic signed [VALUE_W-1:0] cell_ff [CELLS];
   logic signed [VALUE_W-1:0] cell_in [CELLS];

   assign rsp_sorted_value = cell_ff[0];

   always_comb begin
      int  lo;
      int  hi;
      logic desc;
      logic swap;
      cell_in = cell_ff;
      lo      = 0;
      hi      = 0;
      desc    = 1'b0;
      swap    = 1'b0;
      if (cmd.shift_in || cmd.shift_out) begin
         for (int k = 0; k < CELLS - 1; k++) begin
            cell_in[k] = cell_ff[k + 1];
         end
         cell_in[CELLS - 1] = cmd.shift_in ? req_value : cell_ff[0];
      end else if (cmd.cx_en) begin
         for (int r = 0; r < SIDE; r++) begin
            for (int j = 1; j < SIDE; j++) begin
               if (((j & 1) == 1) != cmd.cx_odd) begin
                  if (cmd.cx_col) begin
                     lo   = (j - 1) * SIDE + r;
                     hi   = j * SIDE + r;
                     desc = 1'b0;
                  end else begin
                     lo   = r * SIDE + j - 1;
                     hi   = r * SIDE + j;
                     desc = ((r & 1) == 1);
                  end
                  swap = desc ? (cell_ff[hi] > cell_ff[lo])
                              : (cell_ff[hi] < cell_ff[lo]);
                  if (swap) begin
                     cell_in[lo] = cell_ff[hi];
                     cell_in[hi] = cell_ff[lo];
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
   end

endmodule
